/* hw/rtl/chm_pkg.sv */
`default_nettype none

package chm_pkg;

    localparam logic [63:0] FIB_MULT = 64'd11400714819323198485;
    localparam int          COUNT_W  = 11;

    localparam logic [2:0] REQ_GET    = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_ENSURE = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_DUP       = 2'd3;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_HEAD,
        S_HDATA,
        S_NODE,
        S_CMP,
        S_MISS,
        S_FLINK,
        S_ADD,
        S_UNLINK,
        S_RELINK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/chm_ram.sv */
`default_nettype none

module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/chained_hash_map_engine.sv */
// Channel | Direction | Handshake              | Fields
// in      | input     | i_in_valid/o_in_stall  | i_req_type, i_key, i_value
// out     | output    | o_out_valid/i_out_stall| o_found, o_result_value, o_status,
//         |           |                        | o_entry_count
//
// A request runs through the hash states S_MUL0, S_MUL1 and S_MUL2, the bucket head
// read in S_HEAD and S_HDATA, S_NODE and S_CMP per chain entry visited, any update
// states, S_DONE to hand over the result and S_IDLE; the RAMs have a registered read.
// Clear writes one bucket head RAM word per cycle, for every bucket.
// After reset the same head sweep runs with the input stalled.
// A result waits in the output register while the next item may be accepted.
`default_nettype none

module chained_hash_map_engine #(
    parameter int BUCKET_BITS  = 8,
    parameter int POOL_ENTRIES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [63:0] i_key,
    input  wire logic [63:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_found,
    output logic [63:0]      o_result_value,
    output logic [1:0]       o_status,
    output logic [chm_pkg::COUNT_W-1:0] o_entry_count
);

    localparam int IW = $clog2(POOL_ENTRIES + 1);
    localparam int AW = $clog2(POOL_ENTRIES);
    localparam int NB = 1 << BUCKET_BITS;
    localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);
    localparam logic [BUCKET_BITS-1:0] LAST_BUCKET = BUCKET_BITS'(NB - 1);

    chm_pkg::t_state r_state, n_state;

    logic [2:0]             r_req;
    logic [63:0]            r_key, r_value, r_acc;
    logic [IW-1:0]          r_head, r_cur, r_prev, r_next, r_slot, r_free, r_fresh, r_count;
    logic [BUCKET_BITS-1:0] r_clr_idx;
    logic                   r_clr_reply;
    logic                   r_res_found;
    logic [63:0]            r_res_value;
    logic [1:0]             r_res_status;
    logic                   r_out_found;
    logic [63:0]            r_out_value;
    logic [1:0]             r_out_status;
    logic [IW-1:0]          r_out_count;

    logic [31:0]            mul_a, mul_b;
    logic [63:0]            mul_p;
    logic [BUCKET_BITS-1:0] bucket;

    logic                   b_we;
    logic [BUCKET_BITS-1:0] b_addr;
    logic [IW-1:0]          b_wdata, b_rdata;
    logic                   l_we;
    logic [AW-1:0]          l_addr;
    logic [IW-1:0]          l_wdata, l_rdata;
    logic                   e_we;
    logic [AW-1:0]          e_addr;
    logic [63:0]            k_rdata, v_rdata, v_wdata;

    logic in_take, out_load, is_rem, is_get;

    assign in_take  = i_in_valid && (r_state == chm_pkg::S_IDLE);
    assign out_load = (r_state == chm_pkg::S_DONE) && (!o_out_valid || !i_out_stall);
    assign is_rem   = (r_req == chm_pkg::REQ_REMOVE);
    assign is_get   = (r_req == chm_pkg::REQ_GET);
    assign bucket   = r_acc[63 -: BUCKET_BITS];

    assign o_in_stall     = (r_state != chm_pkg::S_IDLE);
    assign o_found        = r_out_found;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_entry_count  = chm_pkg::COUNT_W'(r_out_count);

    always_comb begin
        mul_a = (r_state == chm_pkg::S_MUL1) ? r_key[63:32] : r_key[31:0];
        mul_b = (r_state == chm_pkg::S_MUL2) ? chm_pkg::FIB_MULT[63:32]
                                              : chm_pkg::FIB_MULT[31:0];
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    chm_ram #(.WIDTH(IW), .DEPTH(NB)) u_head_ram (
        .i_clk(i_clk), .i_we(b_we), .i_addr(b_addr), .i_wdata(b_wdata), .o_rdata(b_rdata)
    );
    chm_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_link_ram (
        .i_clk(i_clk), .i_we(l_we), .i_addr(l_addr), .i_wdata(l_wdata), .o_rdata(l_rdata)
    );
    chm_ram #(.WIDTH(64), .DEPTH(POOL_ENTRIES)) u_key_ram (
        .i_clk(i_clk), .i_we(e_we), .i_addr(e_addr), .i_wdata(r_key), .o_rdata(k_rdata)
    );
    chm_ram #(.WIDTH(64), .DEPTH(POOL_ENTRIES)) u_val_ram (
        .i_clk(i_clk), .i_we(e_we), .i_addr(e_addr), .i_wdata(v_wdata), .o_rdata(v_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            chm_pkg::S_CLR: begin
                if (r_clr_idx == LAST_BUCKET) begin
                    n_state = r_clr_reply ? chm_pkg::S_DONE : chm_pkg::S_IDLE;
                end
            end
            chm_pkg::S_IDLE: begin
                if (in_take) begin
                    if (i_req_type == chm_pkg::REQ_CLEAR) begin
                        n_state = chm_pkg::S_CLR;
                    end else if (i_req_type == chm_pkg::REQ_GET ||
                                 i_req_type == chm_pkg::REQ_INSERT ||
                                 i_req_type == chm_pkg::REQ_ENSURE ||
                                 i_req_type == chm_pkg::REQ_REMOVE) begin
                        n_state = chm_pkg::S_MUL0;
                    end else begin
                        n_state = chm_pkg::S_DONE;
                    end
                end
            end
            chm_pkg::S_MUL0:  n_state = chm_pkg::S_MUL1;
            chm_pkg::S_MUL1:  n_state = chm_pkg::S_MUL2;
            chm_pkg::S_MUL2:  n_state = chm_pkg::S_HEAD;
            chm_pkg::S_HEAD:  n_state = chm_pkg::S_HDATA;
            chm_pkg::S_HDATA: n_state = (b_rdata == NIL) ? chm_pkg::S_MISS : chm_pkg::S_NODE;
            chm_pkg::S_NODE:  n_state = chm_pkg::S_CMP;
            chm_pkg::S_CMP: begin
                if (k_rdata == r_key) begin
                    n_state = is_rem ? chm_pkg::S_UNLINK : chm_pkg::S_DONE;
                end else begin
                    n_state = (l_rdata == NIL) ? chm_pkg::S_MISS : chm_pkg::S_NODE;
                end
            end
            chm_pkg::S_MISS: begin
                if (is_get || is_rem || r_free == NIL) begin
                    n_state = chm_pkg::S_DONE;
                end else if (r_free == r_fresh) begin
                    n_state = chm_pkg::S_ADD;
                end else begin
                    n_state = chm_pkg::S_FLINK;
                end
            end
            chm_pkg::S_FLINK:  n_state = chm_pkg::S_ADD;
            chm_pkg::S_ADD:    n_state = chm_pkg::S_DONE;
            chm_pkg::S_UNLINK: n_state = chm_pkg::S_RELINK;
            chm_pkg::S_RELINK: n_state = chm_pkg::S_DONE;
            chm_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = chm_pkg::S_IDLE;
                end
            end
            default: n_state = chm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        b_we    = 1'b0;
        b_addr  = bucket;
        b_wdata = r_slot;
        l_we    = 1'b0;
        l_addr  = r_cur[AW-1:0];
        l_wdata = r_head;
        e_we    = 1'b0;
        e_addr  = r_cur[AW-1:0];
        v_wdata = (r_req == chm_pkg::REQ_INSERT) ? r_value : 64'd0;
        case (r_state)
            chm_pkg::S_CLR: begin
                b_we    = 1'b1;
                b_addr  = r_clr_idx;
                b_wdata = NIL;
            end
            chm_pkg::S_MISS: begin
                l_addr = r_free[AW-1:0];
            end
            chm_pkg::S_ADD: begin
                b_we    = 1'b1;
                b_wdata = r_slot;
                l_we    = 1'b1;
                l_addr  = r_slot[AW-1:0];
                l_wdata = r_head;
                e_we    = 1'b1;
                e_addr  = r_slot[AW-1:0];
            end
            chm_pkg::S_UNLINK: begin
                if (r_prev == NIL) begin
                    b_we    = 1'b1;
                    b_wdata = r_next;
                end else begin
                    l_we    = 1'b1;
                    l_addr  = r_prev[AW-1:0];
                    l_wdata = r_next;
                end
            end
            chm_pkg::S_RELINK: begin
                l_we    = 1'b1;
                l_addr  = r_cur[AW-1:0];
                l_wdata = r_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chm_pkg::S_CLR;
            r_clr_idx   <= '0;
            r_clr_reply <= 1'b0;
            r_free      <= '0;
            r_fresh     <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                chm_pkg::S_CLR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                end
                chm_pkg::S_IDLE: begin
                    if (in_take && i_req_type == chm_pkg::REQ_CLEAR) begin
                        r_clr_idx   <= '0;
                        r_clr_reply <= 1'b1;
                        r_free      <= '0;
                        r_fresh     <= '0;
                        r_count     <= '0;
                    end
                end
                chm_pkg::S_MISS: begin
                    if (!is_get && !is_rem && r_free != NIL && r_free == r_fresh) begin
                        r_free  <= r_fresh + 1'b1;
                        r_fresh <= r_fresh + 1'b1;
                    end
                end
                chm_pkg::S_FLINK:  r_free  <= l_rdata;
                chm_pkg::S_ADD:    r_count <= r_count + 1'b1;
                chm_pkg::S_RELINK: begin
                    r_free  <= r_cur;
                    r_count <= r_count - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            chm_pkg::S_IDLE: begin
                r_req        <= i_req_type;
                r_key        <= i_key;
                r_value      <= i_value;
                r_res_found  <= 1'b0;
                r_res_value  <= 64'd0;
                r_res_status <= chm_pkg::ST_OK;
            end
            chm_pkg::S_MUL0: r_acc <= mul_p;
            chm_pkg::S_MUL1,
            chm_pkg::S_MUL2: r_acc[63:32] <= r_acc[63:32] + mul_p[31:0];
            chm_pkg::S_HDATA: begin
                r_head <= b_rdata;
                r_cur  <= b_rdata;
                r_prev <= NIL;
            end
            chm_pkg::S_CMP: begin
                if (k_rdata == r_key) begin
                    r_res_found  <= 1'b1;
                    r_res_value  <= v_rdata;
                    r_res_status <= (r_req == chm_pkg::REQ_INSERT) ? chm_pkg::ST_DUP
                                                                   : chm_pkg::ST_OK;
                    r_next       <= l_rdata;
                end else begin
                    r_prev <= r_cur;
                    r_cur  <= l_rdata;
                end
            end
            chm_pkg::S_MISS: begin
                r_slot <= r_free;
                if (is_get || is_rem) begin
                    r_res_status <= chm_pkg::ST_NOT_FOUND;
                end else if (r_free == NIL) begin
                    r_res_status <= chm_pkg::ST_FULL;
                end
            end
            chm_pkg::S_DONE: begin
                if (out_load) begin
                    r_out_found  <= r_res_found;
                    r_out_value  <= r_res_value;
                    r_out_status <= r_res_status;
                    r_out_count  <= r_count;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/chm_checker.sv */
`default_nettype none

module chm_checker #(
    parameter int POOL_ENTRIES = 1024
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_found,
    input wire logic [63:0] o_result_value,
    input wire logic [1:0]  o_status,
    input wire logic [chm_pkg::COUNT_W-1:0] o_entry_count
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
            && $stable(o_status) && $stable(o_found) && $stable(o_entry_count))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_entry_count) <= POOL_ENTRIES)
        else $error("entry count beyond pool");

    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |->
            o_status == chm_pkg::ST_OK || o_status == chm_pkg::ST_DUP)
        else $error("found with miss status");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == chm_pkg::ST_NOT_FOUND || o_status == chm_pkg::ST_FULL)
            |-> !o_found && o_result_value == 64'd0)
        else $error("miss carries a value");

endmodule

bind chained_hash_map_engine chm_checker #(.POOL_ENTRIES(POOL_ENTRIES)) u_chm_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_found(o_found),
    .o_result_value(o_result_value),
    .o_status(o_status),
    .o_entry_count(o_entry_count)
);

`default_nettype wire

/* tb/chained_hash_map_engine_test.sv */
`default_nettype none

module chained_hash_map_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL    = 1024;
    localparam int NBUCKET = 256;
    localparam int NIL     = POOL;
    localparam int LIMIT   = 20000;

    typedef struct packed {
        logic        found;
        logic [63:0] rval;
        logic [1:0]  status;
        logic [10:0] count;
    } t_reply;

    class hash_map_tracker;
        int          head[NBUCKET];
        int          link[POOL];
        logic [63:0] ekey[POOL];
        logic [63:0] evalue[POOL];
        int          free_head;
        int          stored;
        t_reply      pending_replies[$];
        int          mismatches;

        function void wipe();
            foreach (head[i]) head[i] = NIL;
            foreach (link[i]) link[i] = i + 1;
            free_head = 0;
            stored = 0;
        endfunction

        function int bucket_of(logic [63:0] k);
            logic [63:0] p;
            p = k * chm_pkg::FIB_MULT;
            return int'(p[63:56]);
        endfunction

        function int lookup(int b, logic [63:0] k, output int prev);
            int cur;
            int steps;
            cur = head[b];
            prev = NIL;
            steps = 0;
            while (cur < NIL && steps < POOL) begin
                if (ekey[cur] == k) return cur;
                prev = cur;
                cur = link[cur];
                steps++;
            end
            prev = NIL;
            return NIL;
        endfunction

        function void note_request(logic [2:0] req, logic [63:0] k, logic [63:0] v);
            t_reply r;
            int     b;
            int     slot;
            int     prev;
            r = '0;
            b = bucket_of(k);
            case (req)
                chm_pkg::REQ_GET: begin
                    slot = lookup(b, k, prev);
                    if (slot < NIL) begin
                        r.found = 1'b1;
                        r.rval = evalue[slot];
                    end else begin
                        r.status = chm_pkg::ST_NOT_FOUND;
                    end
                end
                chm_pkg::REQ_INSERT, chm_pkg::REQ_ENSURE: begin
                    slot = lookup(b, k, prev);
                    if (slot < NIL) begin
                        r.found = 1'b1;
                        r.rval = evalue[slot];
                        r.status = (req == chm_pkg::REQ_INSERT) ? chm_pkg::ST_DUP
                                                                : chm_pkg::ST_OK;
                    end else if (free_head >= NIL) begin
                        r.status = chm_pkg::ST_FULL;
                    end else begin
                        slot = free_head;
                        free_head = link[slot];
                        ekey[slot] = k;
                        evalue[slot] = (req == chm_pkg::REQ_INSERT) ? v : 64'd0;
                        link[slot] = head[b];
                        head[b] = slot;
                        stored++;
                    end
                end
                chm_pkg::REQ_REMOVE: begin
                    slot = lookup(b, k, prev);
                    if (slot < NIL) begin
                        r.found = 1'b1;
                        r.rval = evalue[slot];
                        if (prev < NIL) link[prev] = link[slot];
                        else head[b] = link[slot];
                        link[slot] = free_head;
                        free_head = slot;
                        stored--;
                    end else begin
                        r.status = chm_pkg::ST_NOT_FOUND;
                    end
                end
                chm_pkg::REQ_CLEAR: wipe();
                default: ;
            endcase
            r.count = stored[10:0];
            pending_replies.push_back(r);
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending_replies.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected found=%0d val=%h status=%0d count=%0d,",
                             want.found, want.rval, want.status, want.count,
                             " got found=%0d val=%h status=%0d count=%0d",
                             got.found, got.rval, got.status, got.count);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_req_type;
    logic [63:0] i_key;
    logic [63:0] i_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_found;
    logic [63:0] o_result_value;
    logic [1:0]  o_status;
    logic [chm_pkg::COUNT_W-1:0] o_entry_count;

    chained_hash_map_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    hash_map_tracker table_model = new();
    logic [63:0]     key_set[96];
    logic [63:0]     live_keys[$];
    bit              no_gaps;
    bit              took_reply;
    int              stall_left;
    int              quiet_cycles;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        took_reply <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && o_out_valid && !i_out_stall)
            table_model.check_reply({o_found, o_result_value, o_status, o_entry_count});
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT) begin
            $display("** chained_hash_map_engine: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (took_reply)
            stall_left = no_gaps ? 0 : $urandom_range(0, 4);
        if (o_out_valid && stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send(logic [2:0] req, logic [63:0] k, logic [63:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key <= k;
        i_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        table_model.note_request(req, k, v);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (table_model.pending_replies.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic mixed_ops(int n);
        logic [63:0] k;
        int          pick;
        repeat (n) begin
            if ($urandom_range(0, 99) < 10) no_gaps = !no_gaps;
            if (live_keys.size() != 0 && $urandom_range(0, 2) == 0)
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else
                k = key_set[$urandom_range(0, 95)];
            pick = $urandom_range(0, 99);
            if (pick < 25) send(chm_pkg::REQ_GET, k, rand64());
            else if (pick < 50) send(chm_pkg::REQ_INSERT, k, rand64());
            else if (pick < 65) send(chm_pkg::REQ_ENSURE, k, rand64());
            else if (pick < 92) send(chm_pkg::REQ_REMOVE, k, rand64());
            else if (pick < 94) send(chm_pkg::REQ_CLEAR, k, rand64());
            else if (pick < 97) send(3'($urandom_range(5, 7)), rand64(), rand64());
            else send(chm_pkg::REQ_INSERT, rand64(), rand64());
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        logic [63:0] k;
        table_model.wipe();
        table_model.mismatches = 0;
        foreach (key_set[i]) key_set[i] = rand64();
        key_set[0] = '0;
        key_set[1] = '1;
        no_gaps = 1'b0;
        stall_left = 0;
        quiet_cycles = 0;
        took_reply = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_req_type = chm_pkg::REQ_GET;
        i_key = '0;
        i_value = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(chm_pkg::REQ_GET, 64'd0, 64'd0);
        send(chm_pkg::REQ_REMOVE, 64'd5, 64'd0);
        send(chm_pkg::REQ_INSERT, 64'd0, 64'd0);
        send(chm_pkg::REQ_INSERT, '1, '1);
        send(chm_pkg::REQ_INSERT, '1, 64'd7);
        send(chm_pkg::REQ_GET, '1, 64'd0);
        send(chm_pkg::REQ_GET, 64'd0, '1);
        send(chm_pkg::REQ_ENSURE, 64'd0, '1);
        send(chm_pkg::REQ_ENSURE, 64'h5555_aaaa_5555_aaaa, '1);
        send(chm_pkg::REQ_GET, 64'h5555_aaaa_5555_aaaa, 64'd0);
        send(3'd5, '1, '1);
        send(3'd6, 64'd0, 64'd0);
        send(3'd7, 64'd0, '1);
        send(chm_pkg::REQ_REMOVE, '1, 64'd0);
        send(chm_pkg::REQ_REMOVE, '1, 64'd0);
        send(chm_pkg::REQ_GET, '1, 64'd0);
        send(chm_pkg::REQ_CLEAR, 64'd0, 64'd0);
        send(chm_pkg::REQ_GET, 64'd0, 64'd0);
        send(chm_pkg::REQ_INSERT, 64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaaa);

        drain();

        while (table_model.stored < POOL) begin
            if ($urandom_range(0, 99) < 10) no_gaps = !no_gaps;
            k = rand64();
            live_keys.push_back(k);
            send($urandom_range(0, 1) ? chm_pkg::REQ_INSERT : chm_pkg::REQ_ENSURE,
                 k, rand64());
        end
        repeat (3) begin
            k = rand64();
            send($urandom_range(0, 1) ? chm_pkg::REQ_INSERT : chm_pkg::REQ_ENSURE,
                 k, rand64());
        end
        no_gaps = 1'b0;
        mixed_ops(20);
        send(chm_pkg::REQ_CLEAR, 64'd0, 64'd0);
        live_keys.delete();
        mixed_ops(5);

        drain();
        repeat (300) @(negedge i_clk);
        if (table_model.mismatches == 0 && table_model.pending_replies.size() == 0)
            $display("** chained_hash_map_engine: PASSED **");
        else
            $display("** chained_hash_map_engine: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire
